// ===== rtl/ciacsp_pkg.sv =====
// ----------------------------------------------------------------------------
// ciacsp_pkg - shared types and constants for the CSP ramp controller
// Field widths, drive state codes, control word codes and the beat layouts
// used by the update logic and the top level.
// ----------------------------------------------------------------------------
package ciacsp_pkg;

   localparam int StatusW = 16;
   localparam int PosW    = 32;
   localparam int StepW   = 20;
   localparam int CtrlW   = 16;

   // status word: fault flag and the low ten state bits
   localparam int FaultBit = 3;
   localparam int StateW   = 10;

   localparam logic [StateW-1:0] StShutdownA  = 10'h250;
   localparam logic [StateW-1:0] StShutdownB  = 10'h270;
   localparam logic [StateW-1:0] StSwitchedOn = 10'h231;
   localparam logic [StateW-1:0] StEnabled    = 10'h233;

   // control word codes sent to the drive
   localparam logic [CtrlW-1:0] CwIdle       = 16'h0000;
   localparam logic [CtrlW-1:0] CwShutdown   = 16'h0006;
   localparam logic [CtrlW-1:0] CwSwitchOn   = 16'h0007;
   localparam logic [CtrlW-1:0] CwEnableOp   = 16'h000F;
   localparam logic [CtrlW-1:0] CwFaultReset = 16'h0080;

   // tolerated drift between reported and actual position while idle
   localparam logic [PosW-1:0] DriftLimit = 32'd3;

   localparam logic [StepW-1:0] MaxStepReset = 20'd300;

   // request beat, last field in the lowest bits
   typedef struct packed {
      logic                   reverse;
      logic                   run;
      logic signed [PosW-1:0] actual_position;
      logic [StatusW-1:0]     drive_status;
   } req_type;

   // response beat, last field in the lowest bits
   typedef struct packed {
      logic [StepW-1:0]       step_size;
      logic signed [PosW-1:0] reported_position;
      logic signed [PosW-1:0] target_position;
      logic [CtrlW-1:0]       ctrl_cmd;
   } rsp_type;

endpackage

// ===== rtl/ciacsp_update.sv =====
// ----------------------------------------------------------------------------
// ciacsp_update - drive state machine and position ramp state
// Holds control word, target, step and reported position, and works out
// their next values from one registered request beat.
// ----------------------------------------------------------------------------
module ciacsp_update
   import ciacsp_pkg::*;
#(
   parameter int RAMP_STEP = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  req_type          req,
   input  logic [StepW-1:0] max_step,
   output rsp_type          nxt
);

   localparam logic [StepW-1:0] RampStep = StepW'(RAMP_STEP);
   localparam logic [PosW-1:0]  DriftNeg = ~DriftLimit + 32'd1;

   logic [CtrlW-1:0] control_ff, control_in;
   logic [PosW-1:0]  target_ff, target_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [PosW-1:0]  reported_ff, reported_in;

   logic [CtrlW-1:0] cw_pick;
   logic [StepW:0]   step_up;
   logic [StepW-1:0] step_dn;
   logic [StepW-1:0] step_move;
   logic [PosW-1:0]  moved;
   logic [PosW-1:0]  drift;
   logic             drift_small;

   // pick the control word from the drive status
   always_comb begin
      cw_pick = control_ff;
      if (req.drive_status[FaultBit]) begin
         cw_pick = CwFaultReset;
      end else begin
         case (req.drive_status[StateW-1:0]) inside
            StShutdownA, StShutdownB: cw_pick = CwShutdown;
            StSwitchedOn:             cw_pick = CwSwitchOn;
            StEnabled:                cw_pick = CwEnableOp;
            default:                  cw_pick = control_ff;
         endcase
      end
   end

   // ramp the step up to the ceiling or down to zero, move the target by it and measure the drift
   always_comb begin
      step_up = {1'b0, step_ff} + {1'b0, RampStep};
      if (step_ff <= RampStep) begin
         step_dn = '0;
      end else begin
         step_dn = step_ff - RampStep;
      end
      if (req.run) begin
         step_move = (step_up >= {1'b0, max_step}) ? max_step : step_up[StepW-1:0];
      end else begin
         step_move = step_dn;
      end
      if (req.reverse) begin
         moved = target_ff - PosW'(step_move);
      end else begin
         moved = target_ff + PosW'(step_move);
      end
      drift       = reported_ff - req.actual_position;
      drift_small = (drift <= DriftLimit) || (drift >= DriftNeg);
   end

   // next state for one beat
   always_comb begin
      control_in  = cw_pick;
      target_in   = target_ff;
      step_in     = step_ff;
      reported_in = reported_ff;
      if (req.run || (step_ff != '0)) begin
         if (cw_pick == CwSwitchOn) begin
            target_in = req.actual_position;
         end else if (cw_pick == CwEnableOp) begin
            step_in     = step_move;
            target_in   = moved;
            reported_in = moved;
         end
      end else begin
         // stopped and idle: follow the drive
         target_in  = req.actual_position;
         control_in = CwIdle;
         if (!drift_small) begin
            reported_in = req.actual_position;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff  <= CwIdle;
         target_ff   <= '0;
         step_ff     <= '0;
         reported_ff <= '0;
      end else if (advance) begin
         control_ff  <= control_in;
         target_ff   <= target_in;
         step_ff     <= step_in;
         reported_ff <= reported_in;
      end
   end

   assign nxt.ctrl_cmd          = control_in;
   assign nxt.target_position   = target_in;
   assign nxt.reported_position = reported_in;
   assign nxt.step_size         = step_in;

endmodule

// ===== rtl/cia402_csp_ramp_controller_unit.sv =====
// ----------------------------------------------------------------------------
// cia402_csp_ramp_controller_unit - CiA402 control word and CSP position ramp
// One request beat per bus cycle in, one response beat out, while responses are taken.
// ----------------------------------------------------------------------------
// Each request beat is registered, passed through one stage of update logic
// and lands in the response register, which raises rsp_tvalid; the block
// sustains one beat per clock while the response is taken.
// The drive state and ramp registers are updated as each beat moves into the
// response register, which is what lets the next beat follow straight away.
// The response register decouples the two sides: a new beat is taken while a
// result waits, and both sides stall only when the response is not taken.
// max_step resets to 300 and is written through the csr_ channel, always
// ready; write it only while no beat is in flight.
module cia402_csp_ramp_controller_unit
   import ciacsp_pkg::*;
#(
   parameter int RAMP_STEP = 10
) (
   input  logic         clock,
   input  logic         reset,
   // drive_status[15:0], actual_position[47:16], run[48], reverse[49], zero fill
   input  logic [55:0]  req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // ctrl_cmd[15:0], target_position[47:16], reported_position[79:48],
   // step_size[99:80], zero fill
   output logic [103:0] rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [19:0]  csr_data,
   input  logic         csr_valid,
   output logic         csr_ready
);

   localparam int ReqW = $bits(req_type);
   localparam int RspW = $bits(rsp_type);

   logic             req_valid_ff;
   req_type          req_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   logic [StepW-1:0] max_step_ff;
   logic             advance;
   rsp_type          nxt;

   // move a beat on when the response slot is free or being emptied
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // hold the step ceiling
   always_ff @(posedge clock) begin
      if (reset) begin
         max_step_ff <= MaxStepReset;
      end else if (csr_valid) begin
         max_step_ff <= csr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= req_type'(req_tdata[ReqW-1:0]);
      end
   end

   ciacsp_update #(
      .RAMP_STEP (RAMP_STEP)
   ) u_update (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .req      (req_ff),
      .max_step (max_step_ff),
      .nxt      (nxt)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= nxt;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(104 - RspW)'(0), rsp_ff};

endmodule

// ===== rtl/ciacsp_checker.sv =====
// ----------------------------------------------------------------------------
// ciacsp_checker - port level checks for the CSP ramp controller
// Watches the stream ports and flags responses the controller cannot give.
// ----------------------------------------------------------------------------
module ciacsp_checker
   import ciacsp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [103:0] rsp_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready
);

   logic [CtrlW-1:0] cw;
   logic [StepW-1:0] step;

   assign cw   = rsp_tdata[15:0];
   assign step = rsp_tdata[99:80];

   // a stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // only the known control words leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (cw == CwIdle || cw == CwShutdown || cw == CwSwitchOn ||
                      cw == CwEnableOp || cw == CwFaultReset))
      else $error("unexpected control word");

   // idle is only reported once the ramp has run down
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && cw == CwIdle |-> step == '0)
      else $error("idle control word with nonzero step");

   // the request side only stalls behind a waiting response
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled with no waiting response");

   // no response straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind cia402_csp_ramp_controller_unit ciacsp_checker u_ciacsp_checker (.*);
